/* src/mws_pkg.sv */
// mws_pkg: constants, stopword table and controller/datapath interface types
// for the minhash word signature core. No dependencies.
package mws_pkg;

  localparam logic [63:0] FNV_BASIS    = 64'h1465_0FB0_739D_0383;
  localparam logic [63:0] FNV_PRIME    = 64'h0000_0100_0000_01B3;
  // prime = 2^40 + low part
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
  localparam int          PRIME_SHIFT  = 40;

  localparam int HEAD_CHARS = 6;
  localparam int HEAD_W     = 8 * HEAD_CHARS;
  localparam int LEN_ARG_W  = 6;
  localparam int STOP_COUNT = 21;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [2:0]        len;
  } stop_entry_t;

  // first char in the low byte
  localparam stop_entry_t STOP_LIST [STOP_COUNT] = '{
    '{48'h0000_0065_6874, 3'd3},  // the
    '{48'h0000_0000_0061, 3'd1},  // a
    '{48'h0000_0000_6E61, 3'd2},  // an
    '{48'h6573_6165_6C70, 3'd6},  // please
    '{48'h0000_0000_6F74, 3'd2},  // to
    '{48'h0000_0000_666F, 3'd2},  // of
    '{48'h0000_0064_6E61, 3'd3},  // and
    '{48'h0000_0000_7369, 3'd2},  // is
    '{48'h0000_0065_7261, 3'd3},  // are
    '{48'h0000_0000_6E69, 3'd2},  // in
    '{48'h0000_0000_6E6F, 3'd2},  // on
    '{48'h0000_0000_7461, 3'd2},  // at
    '{48'h0000_0072_6F66, 3'd3},  // for
    '{48'h0000_6874_6977, 3'd4},  // with
    '{48'h0000_7369_6874, 3'd4},  // this
    '{48'h0000_7461_6874, 3'd4},  // that
    '{48'h0000_0000_7469, 3'd2},  // it
    '{48'h0000_0000_6562, 3'd2},  // be
    '{48'h0000_006E_6163, 3'd3},  // can
    '{48'h0000_0075_6F79, 3'd3},  // you
    '{48'h0000_0000_656D, 3'd2}   // me
  };

  function automatic logic head_in_stop_list(input logic [HEAD_W-1:0] head,
                                             input logic [LEN_ARG_W-1:0] len);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < STOP_COUNT; i++) begin
      if (len == LEN_ARG_W'(STOP_LIST[i].len) && head == STOP_LIST[i].head) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  typedef struct packed {
    logic take;        // latch accepted byte
    logic mul0;        // hash partial product low x low
    logic mul1;        // low x high
    logic mul2;        // high x low, write back
    logic upd_init;    // start signature update sweep
    logic ram_rd;      // read signature entry k
    logic upd_wr;      // compare and keep minimum at k
    logic emit_ld;     // load result register from entry k
    logic k_inc;
    logic k_clr;
    logic clear_word;
  } mws_cmd_t;

  typedef struct packed {
    logic char_word;   // incoming byte is a letter or digit
    logic len_full;    // word already at its length cap
    logic text_end;    // latched byte was zero
    logic word_ok;     // open word is nonempty and not a stopword
    logic k_last;
    logic out_free;    // result register free at this edge
  } mws_sts_t;

endpackage

/* src/mws_ram.sv */
// mws_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mws_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/mws_ctrl.sv */
// mws_ctrl: sequencing state machine for the minhash word signature core.
// Depends on mws_pkg for the command and status types.
module mws_ctrl import mws_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mws_sts_t sts,
  output mws_cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE, MUL0, MUL1, MUL2, FIN, UPD_RD, UPD_WR, EMIT_RD, EMIT_LD
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.char_word) begin
            state_nxt = sts.len_full ? IDLE : MUL0;
          end else begin
            state_nxt = FIN;
          end
        end
      end
      MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = MUL1;
      end
      MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = MUL2;
      end
      MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = IDLE;
      end
      FIN: begin
        if (sts.word_ok) begin
          cmd.upd_init = 1'b1;
          state_nxt    = UPD_RD;
        end else begin
          cmd.clear_word = 1'b1;
          cmd.k_clr      = 1'b1;
          state_nxt      = sts.text_end ? EMIT_RD : IDLE;
        end
      end
      UPD_RD: begin
        cmd.ram_rd = 1'b1;
        state_nxt  = UPD_WR;
      end
      UPD_WR: begin
        cmd.upd_wr = 1'b1;
        if (sts.k_last) begin
          cmd.clear_word = 1'b1;
          cmd.k_clr      = 1'b1;
          state_nxt      = sts.text_end ? EMIT_RD : IDLE;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = UPD_RD;
        end
      end
      EMIT_RD: begin
        if (sts.out_free) begin
          cmd.ram_rd = 1'b1;
          state_nxt  = EMIT_LD;
        end
      end
      EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        if (sts.k_last) begin
          state_nxt = IDLE;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = EMIT_RD;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != IDLE);
    end
  end

  assign in_stall = in_stall_r;

  a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall_r |-> state_r == IDLE)
    else $error("input open outside idle");

  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == MUL0 |=> state_r == MUL1 ##1 state_r == MUL2)
    else $error("hash multiply steps out of order");

endmodule

/* src/mws_dp.sv */
// mws_dp: datapath of the minhash word signature core: word hashing with a
// shared 32x32 multiplier, stopword check, signature RAM and result register.
// Depends on mws_pkg and mws_ram.
module mws_dp import mws_pkg::*; #(
  parameter int SIG_COUNT    = 16,
  parameter int MAX_WORD_LEN = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_text_byte,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [3:0]  out_sig_position,
  output logic [63:0] out_sig_value,
  output logic        out_sig_last,
  input  mws_cmd_t    cmd,
  output mws_sts_t    sts
);

  localparam int KW   = (SIG_COUNT > 1) ? $clog2(SIG_COUNT) : 1;
  localparam int LENW = $clog2(MAX_WORD_LEN + 1);

  logic [7:0]        lc;
  logic              char_word;
  logic [7:0]        c_r;
  logic [63:0]       h1_r, h2_r, x2_r, acc_r;
  logic [63:0]       x1, h1_mul;
  logic [LENW-1:0]   len_r;
  logic [HEAD_W-1:0] head_r;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic [KW-1:0]     k_r;
  logic [63:0]       hk_r, step_r;
  logic [SIG_COUNT-1:0] valid_r;
  logic [63:0]       rdata, cur;
  logic              less;
  logic              out_valid_r, out_last_r;
  logic [3:0]        out_pos_r;
  logic [63:0]       out_value_r;

  // fold upper case and classify the incoming byte
  always_comb begin
    lc = in_text_byte;
    if (in_text_byte inside {[8'h41:8'h5A]}) begin
      lc = in_text_byte + 8'h20;
    end
    char_word = (lc inside {[8'h61:8'h7A], [8'h30:8'h39]});
  end

  // h1 * prime: prime is 2^40 plus a 9-bit constant
  assign x1     = h1_r ^ {56'd0, c_r};
  assign h1_mul = x1 * {55'd0, FNV_PRIME_LO} + (x1 << PRIME_SHIFT);

  // h2 * basis mod 2^64 from three 32x32 partial products
  assign mul_a = cmd.mul2 ? x2_r[63:32] : x2_r[31:0];
  assign mul_b = cmd.mul1 ? FNV_BASIS[63:32] : FNV_BASIS[31:0];
  assign prod  = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r   <= FNV_BASIS;
      h2_r   <= FNV_PRIME;
      len_r  <= '0;
      head_r <= '0;
    end else if (cmd.clear_word) begin
      h1_r   <= FNV_BASIS;
      h2_r   <= FNV_PRIME;
      len_r  <= '0;
      head_r <= '0;
    end else begin
      if (cmd.mul0) begin
        h1_r <= h1_mul;
        if (len_r < LENW'(HEAD_CHARS)) begin
          head_r[{len_r[2:0], 3'b000} +: 8] <= c_r;
        end
        len_r <= len_r + 1'b1;
      end
      if (cmd.mul2) begin
        h2_r <= acc_r + {prod[31:0], 32'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      c_r  <= lc;
      x2_r <= h2_r ^ {56'd0, lc};
    end
    if (cmd.mul0) begin
      acc_r <= prod;
    end else if (cmd.mul1) begin
      acc_r <= acc_r + {prod[31:0], 32'd0};
    end
  end

  // signature sweep
  mws_ram #(
    .WIDTH (64),
    .DEPTH (SIG_COUNT)
  ) u_sig_ram (
    .clk   (clk),
    .we    (cmd.upd_wr && less),
    .waddr (k_r),
    .wdata (hk_r),
    .re    (cmd.ram_rd),
    .raddr (k_r),
    .rdata (rdata)
  );

  assign cur  = valid_r[k_r] ? rdata : '1;
  assign less = (hk_r < cur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      valid_r <= '0;
    end else begin
      if (cmd.upd_init || cmd.k_clr) begin
        k_r <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd.upd_wr && less) begin
        valid_r[k_r] <= 1'b1;
      end else if (cmd.emit_ld) begin
        valid_r[k_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_init) begin
      hk_r   <= h1_r;
      step_r <= h2_r | 64'd1;
    end else if (cmd.upd_wr) begin
      hk_r <= hk_r + step_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_pos_r   <= 4'(k_r);
      out_value_r <= cur;
      out_last_r  <= sts.k_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sig_position = out_pos_r;
  assign out_sig_value    = out_value_r;
  assign out_sig_last     = out_last_r;

  always_comb begin
    sts.char_word = char_word;
    sts.len_full  = (len_r == LENW'(MAX_WORD_LEN));
    sts.text_end  = (c_r == 8'd0);
    sts.word_ok   = (len_r != '0) && !head_in_stop_list(head_r, LEN_ARG_W'(len_r));
    sts.k_last    = (k_r == KW'(SIG_COUNT - 1));
    sts.out_free  = !out_valid_r || !out_stall;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ld |-> !out_valid_r)
    else $error("result register overwritten");

  a_sig_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ld && sts.k_last |=> valid_r == '0)
    else $error("signature not cleared after text end");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LENW'(MAX_WORD_LEN))
    else $error("word length beyond cap");

endmodule

/* src/minhash_word_signature_core.sv */
// minhash_word_signature_core: top level of the minhash word signature core.
// Depends on mws_pkg, mws_ctrl, mws_dp (which holds mws_ram).
//
// Takes text one byte per request and returns a MinHash signature of its
// words when a zero byte arrives. A letter or digit is accepted and then
// takes the MUL0, MUL1 and MUL2 steps on the shared 32x32 multiplier for the
// second hash; other bytes are accepted and then end the word in FIN, which
// for a word that is kept also sweeps the signature RAM, since each position
// is read, compared and written back one at a time. A zero byte then
// emits SIG_COUNT results one at a time, held while the output is stalled.
// Characters beyond MAX_WORD_LEN are accepted and dropped. The signature
// starts as all ones after reset and after every zero byte.
module minhash_word_signature_core import mws_pkg::*; #(
  parameter int SIG_COUNT    = 16,
  parameter int MAX_WORD_LEN = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_sig_position,
  output logic [63:0] out_sig_value,
  output logic        out_sig_last
);

  mws_cmd_t cmd;
  mws_sts_t sts;

  mws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mws_dp #(
    .SIG_COUNT    (SIG_COUNT),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_text_byte     (in_text_byte),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_sig_position (out_sig_position),
    .out_sig_value    (out_sig_value),
    .out_sig_last     (out_sig_last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
